[sv/gregorian_date_adder_defines.svh]
// assertion macros for the date adder rtl
`ifndef GREGORIAN_DATE_ADDER_DEFINES_SVH
`define GREGORIAN_DATE_ADDER_DEFINES_SVH

// same-cycle implication on the block clock, off during reset
`define GDA_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on the block clock, off during reset
`define GDA_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/gda_pkg.sv]
package gda_pkg;

  // widths of the working registers
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned ADD_W   = 16;
  localparam int unsigned LEN_W   = 5;
  localparam int unsigned WDAY_W  = 3;
  localparam int unsigned WORK_W  = 17;   // day sum and year both fit
  localparam int unsigned YFULL_W = 15;   // year before reduction
  localparam int unsigned STEP_W  = 3;
  localparam int unsigned CENT_W  = 8;    // year / 100
  localparam int unsigned ZSUM_W  = 11;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
  localparam logic [MONTH_W-1:0] MONTH_JUL = 4'd7;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [WORK_W-1:0] CYCLE_YEARS = 17'd400;
  localparam logic [WORK_W-1:0] CENTURY     = 17'd100;
  localparam logic [WORK_W-1:0] WEEK_DAYS   = 17'd7;

  // top shift of each shift-subtract pass
  localparam logic [STEP_W-1:0] MOD400_TOP = 3'd6;
  localparam logic [STEP_W-1:0] DIV100_TOP = 3'd7;
  localparam logic [STEP_W-1:0] MOD7_TOP   = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD400,
    ST_MONTH,
    ST_ZPREP,
    ST_DIV100,
    ST_ZSUM,
    ST_MOD7,
    ST_DONE
  } gda_state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_MOD400,
    OP_MONTH,
    OP_DIV100,
    OP_MOD7
  } gda_op_e;

  typedef struct packed {
    logic              idle;
    gda_op_e           op;
    logic [STEP_W-1:0] step;
    logic              zprep;
    logic              zsum;
    logic              finish;
  } gda_ctl_t;

  typedef struct packed {
    logic start;
    logic month_more;
    logic out_free;
  } gda_sts_t;

  typedef struct packed {
    logic [DAY_W-1:0]   start_day;
    logic [MONTH_W-1:0] start_month;
    logic [YEAR_W-1:0]  start_year;
    logic [ADD_W-1:0]   add_count;
  } gda_in_t;

  typedef struct packed {
    logic [DAY_W-1:0]   new_day;
    logic [MONTH_W-1:0] new_month;
    logic [YEAR_W-1:0]  new_year;
    logic               leap_flag;
    logic [LEN_W-1:0]   month_length;
    logic [WDAY_W-1:0]  weekday;
    logic [DAY_W-1:0]   next_day;
    logic [MONTH_W-1:0] next_month;
    logic [YEAR_W-1:0]  next_year;
  } gda_out_t;

  // leap rule from the year reduced mod 400
  function automatic logic leap_of_r400(logic [8:0] r);
    return (r[1:0] == 2'b00) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
  endfunction

  function automatic logic [LEN_W-1:0] month_len(logic [MONTH_W-1:0] m, logic leap);
    logic [LEN_W-1:0] len;
    if (m == MONTH_FEB) begin
      len = leap ? 5'd29 : 5'd28;
    end else if (m <= MONTH_JUL) begin
      len = 5'd30 + {4'b0, m[0]};
    end else begin
      len = 5'd31 - {4'b0, m[0]};
    end
    return len;
  endfunction

  // floor(13 * (m + 1) / 5) for the shifted months 3..14
  function automatic logic [5:0] zeller_month_term(logic [MONTH_W-1:0] m);
    logic [5:0] t;
    case (m)
      4'd3:    t = 6'd10;
      4'd4:    t = 6'd13;
      4'd5:    t = 6'd15;
      4'd6:    t = 6'd18;
      4'd7:    t = 6'd20;
      4'd8:    t = 6'd23;
      4'd9:    t = 6'd26;
      4'd10:   t = 6'd28;
      4'd11:   t = 6'd31;
      4'd12:   t = 6'd33;
      4'd13:   t = 6'd36;
      4'd14:   t = 6'd39;
      default: t = 6'd0;
    endcase
    return t;
  endfunction

endpackage

[sv/gda_sub.sv]
module gda_sub
  import gda_pkg::*;
(
  input  logic [WORK_W-1:0] a_i,
  input  logic [WORK_W-1:0] b_i,
  output logic [WORK_W-1:0] diff_o,
  output logic              borrow_o
);

  logic [WORK_W:0] full;

  assign full     = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o   = full[WORK_W-1:0];
  assign borrow_o = full[WORK_W];

endmodule

[sv/gda_seq.sv]
module gda_seq
  import gda_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  gda_sts_t sts_i,
  output gda_ctl_t ctl_o
);

  gda_state_e        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  // next state and step counter
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE: begin
        if (sts_i.start) begin
          state_d = ST_MOD400;
          step_d  = MOD400_TOP;
        end
      end
      ST_MOD400: begin
        step_d = step_q - 3'd1;
        if (step_q == '0) state_d = ST_MONTH;
      end
      ST_MONTH: begin
        if (!sts_i.month_more) state_d = ST_ZPREP;
      end
      ST_ZPREP: begin
        state_d = ST_DIV100;
        step_d  = DIV100_TOP;
      end
      ST_DIV100: begin
        step_d = step_q - 3'd1;
        if (step_q == '0) state_d = ST_ZSUM;
      end
      ST_ZSUM: begin
        state_d = ST_MOD7;
        step_d  = MOD7_TOP;
      end
      ST_MOD7: begin
        step_d = step_q - 3'd1;
        if (step_q == '0) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control word
  always_comb begin
    ctl_o        = '0;
    ctl_o.op     = OP_NONE;
    ctl_o.step   = step_q;
    case (state_q)
      ST_IDLE:   ctl_o.idle   = 1'b1;
      ST_MOD400: ctl_o.op     = OP_MOD400;
      ST_MONTH:  ctl_o.op     = OP_MONTH;
      ST_ZPREP:  ctl_o.zprep  = 1'b1;
      ST_DIV100: ctl_o.op     = OP_DIV100;
      ST_ZSUM:   ctl_o.zsum   = 1'b1;
      ST_MOD7:   ctl_o.op     = OP_MOD7;
      ST_DONE:   ctl_o.finish = sts_i.out_free;
      default:   ctl_o.idle   = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

[sv/gregorian_date_adder.sv]
// channel  | dir | handshake                       | payload
// in       | in  | in_valid_i / in_stall_o         | in_data_i  (gda_in_t)
// out      | out | out_valid_o / out_stall_i       | out_data_o (gda_out_t)
//
// per item: a month loop on the shared subtractor runs once per month crossed by the offset
//   plus one final check, so the offset sets how long an item takes
// fixed passes: accept in idle, year mod 400, zeller prep, year / 100,
//   sum, mod 7, result write; the month loop runs between year mod 400 and zeller prep
// reset clears the sequencer and the output valid, payload registers are not reset
// input is stalled from transfer until the result is written to the output register;
//   a stalled output holds the block in its last state
`include "gregorian_date_adder_defines.svh"

module gregorian_date_adder
  import gda_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  gda_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output gda_out_t out_data_o
);

  gda_ctl_t ctl;
  gda_sts_t sts;

  // working registers
  logic [WORK_W-1:0]  d_q;      // running day of month
  logic [MONTH_W-1:0] m_q;
  logic [YFULL_W-1:0] y_q;      // unreduced year
  logic [WORK_W-1:0]  w_q;      // shared remainder: y mod 400, then zeller year (mod 100), then sum (mod 7)
  logic [CENT_W-1:0]  j_q;      // zeller century
  logic [MONTH_W-1:0] mz_q;     // zeller month 3..14
  logic               leap_q;
  logic [LEN_W-1:0]   len_q;

  logic     out_valid_q;
  gda_out_t out_q;

  // shared subtractor operands
  logic [WORK_W-1:0] sub_a, sub_b, sub_diff;
  logic              sub_borrow;
  logic              cur_leap;
  logic [LEN_W-1:0]  cur_len;
  logic              in_xfer;

  assign cur_leap = leap_of_r400(w_q[8:0]);
  assign cur_len  = month_len(m_q, cur_leap);
  assign in_xfer  = in_valid_i && !in_stall_o;

  always_comb begin
    sub_a = w_q;
    case (ctl.op)
      OP_MOD400: sub_b = CYCLE_YEARS << ctl.step;
      OP_MONTH: begin
        sub_a = d_q;
        sub_b = {{(WORK_W-LEN_W){1'b0}}, cur_len};
      end
      OP_DIV100: sub_b = CENTURY << ctl.step;
      OP_MOD7:   sub_b = WEEK_DAYS << ctl.step;
      default:   sub_b = '0;
    endcase
  end

  gda_sub u_sub (
    .a_i      (sub_a),
    .b_i      (sub_b),
    .diff_o   (sub_diff),
    .borrow_o (sub_borrow)
  );

  assign sts.start      = in_xfer;
  // day still beyond the month: strictly greater keeps the last day
  assign sts.month_more = !sub_borrow && (sub_diff != '0);
  assign sts.out_free   = !out_valid_q || !out_stall_i;

  gda_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .ctl_o  (ctl)
  );

  assign in_stall_o = !ctl.idle;

  // zeller sum terms
  logic [ZSUM_W-1:0] zsum;
  logic [6:0]        zk;
  assign zk   = w_q[6:0];
  assign zsum = ZSUM_W'(d_q[DAY_W-1:0]) + ZSUM_W'(zeller_month_term(mz_q))
              + ZSUM_W'(zk) + ZSUM_W'(zk[6:2]) + ZSUM_W'(j_q[CENT_W-1:2])
              + ZSUM_W'({j_q, 2'b00}) + ZSUM_W'(j_q);

  // next-day date
  logic [DAY_W:0]     nd_full;
  logic               nd_wrap;
  logic [DAY_W-1:0]   nd;
  logic [MONTH_W-1:0] nm;
  logic [YFULL_W-1:0] ny;

  always_comb begin
    nd_full = {1'b0, d_q[DAY_W-1:0]} + 6'd1;
    nd_wrap = nd_full > {1'b0, len_q};
    nd      = nd_wrap ? 5'd1 : nd_full[DAY_W-1:0];
    nm      = m_q;
    ny      = y_q;
    if (nd_wrap) begin
      if (m_q == MONTH_DEC) begin
        nm = MONTH_JAN;
        ny = y_q + 15'd1;
      end else begin
        nm = m_q + 4'd1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      d_q <= WORK_W'(in_data_i.start_day) + WORK_W'(in_data_i.add_count);
      // months outside 1..12 count as january
      if (in_data_i.start_month == '0 || in_data_i.start_month > MONTH_DEC) begin
        m_q <= MONTH_JAN;
      end else begin
        m_q <= in_data_i.start_month;
      end
      y_q <= YFULL_W'(in_data_i.start_year);
      w_q <= WORK_W'(in_data_i.start_year);
    end
    case (ctl.op)
      OP_MOD400, OP_MOD7: begin
        if (!sub_borrow) w_q <= sub_diff;
      end
      OP_DIV100: begin
        if (!sub_borrow) begin
          w_q           <= sub_diff;
          j_q[ctl.step] <= 1'b1;
        end
      end
      OP_MONTH: begin
        if (sts.month_more) begin
          d_q <= sub_diff;
          if (m_q == MONTH_DEC) begin
            m_q <= MONTH_JAN;
            y_q <= y_q + 15'd1;
            w_q <= (w_q == CYCLE_YEARS - 17'd1) ? '0 : w_q + 17'd1;
          end else begin
            m_q <= m_q + 4'd1;
          end
        end else begin
          leap_q <= cur_leap;
          len_q  <= cur_len;
        end
      end
      default: ;
    endcase
    if (ctl.zprep) begin
      // january and february count as months 13 and 14 of the year before
      if (m_q < MONTH_MAR) begin
        mz_q <= m_q + 4'd12;
        w_q  <= WORK_W'(y_q) + CYCLE_YEARS - 17'd1;
      end else begin
        mz_q <= m_q;
        w_q  <= WORK_W'(y_q) + CYCLE_YEARS;
      end
      j_q <= '0;
    end
    if (ctl.zsum) begin
      w_q <= WORK_W'(zsum);
    end
    if (ctl.finish) begin
      out_q.new_day      <= d_q[DAY_W-1:0];
      out_q.new_month    <= m_q;
      out_q.new_year     <= y_q[YEAR_W-1:0];
      out_q.leap_flag    <= leap_q;
      out_q.month_length <= len_q;
      out_q.weekday      <= w_q[WDAY_W-1:0];
      out_q.next_day     <= nd;
      out_q.next_month   <= nm;
      out_q.next_year    <= ny[YEAR_W-1:0];
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `GDA_ASSERT_IMP(a_r400_range, ctl.op == OP_MONTH, w_q < CYCLE_YEARS, "year residue out of range")
  `GDA_ASSERT_IMP(a_day_fits, ctl.zprep, d_q <= WORK_W'(len_q), "day exceeds month length")
  `GDA_ASSERT_IMP(a_week_range, ctl.finish, w_q < WEEK_DAYS, "weekday not reduced")
  `GDA_ASSERT_IMP(a_out_src, $rose(out_valid_q), $past(ctl.finish), "result without finish")

endmodule

[tb/sv/tb_gregorian_date_adder.sv]
module tb_gregorian_date_adder
  import gda_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // scoreboard: predicts the advanced date for each input transfer
  // and checks the output transfers against it in order
  class date_scoreboard;
    gda_out_t    due_q[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned noted;
    int unsigned wrapped_years;
    int unsigned fixed_months;
    int unsigned leap_results;

    function automatic bit is_leap(int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned days_in(int unsigned m, int unsigned y);
      if (m == 2) begin
        return is_leap(y) ? 29 : 28;
      end
      if (m < 8) begin
        return 30 + (m % 2);
      end
      return 31 - (m % 2);
    endfunction

    // walk month by month, keep the year unreduced until written out
    function automatic gda_out_t advance_date(gda_in_t a);
      gda_out_t    r;
      int unsigned d, m, y, len, nd, nm, ny, zm, zy, k, j;
      d = a.start_day;
      m = a.start_month;
      y = a.start_year;
      if (m < 1 || m > 12) begin
        m = 1;
      end
      d += a.add_count;
      while (d > days_in(m, y)) begin
        d -= days_in(m, y);
        m++;
        if (m > 12) begin
          m = 1;
          y++;
        end
      end
      len = days_in(m, y);
      nd  = d + 1;
      nm  = m;
      ny  = y;
      if (nd > len) begin
        nd = 1;
        nm++;
      end
      if (nm > 12) begin
        nm = 1;
        ny++;
      end
      // zeller with a full 400 year cycle added so year zero stays positive
      zy = y + 400;
      zm = m;
      if (zm < 3) begin
        zm += 12;
        zy -= 1;
      end
      k = zy % 100;
      j = zy / 100;
      r.new_day      = DAY_W'(d);
      r.new_month    = MONTH_W'(m);
      r.new_year     = YEAR_W'(y);
      r.leap_flag    = is_leap(y);
      r.month_length = LEN_W'(len);
      r.weekday      = WDAY_W'((d + (13 * (zm + 1)) / 5 + k + k / 4 + j / 4 + 5 * j) % 7);
      r.next_day     = DAY_W'(nd);
      r.next_month   = MONTH_W'(nm);
      r.next_year    = YEAR_W'(ny);
      if (y >= (1 << YEAR_W) || ny >= (1 << YEAR_W)) begin
        wrapped_years++;
      end
      if (r.leap_flag) begin
        leap_results++;
      end
      return r;
    endfunction

    function void note_input(gda_in_t a);
      noted++;
      if (a.start_month < 1 || a.start_month > 12) begin
        fixed_months++;
      end
      due_q.push_back(advance_date(a));
    endfunction

    function void match(string name, int unsigned exp, int unsigned got);
      if (exp != got) begin
        mismatches++;
        $error("%s: expected %0d, got %0d", name, exp, got);
      end
    endfunction

    function void check_result(gda_out_t got);
      gda_out_t exp;
      if (due_q.size() == 0) begin
        mismatches++;
        $error("result transfer with no input pending");
        return;
      end
      exp = due_q.pop_front();
      checked++;
      match("new_day",      exp.new_day,      got.new_day);
      match("new_month",    exp.new_month,    got.new_month);
      match("new_year",     exp.new_year,     got.new_year);
      match("leap_flag",    exp.leap_flag,    got.leap_flag);
      match("month_length", exp.month_length, got.month_length);
      match("weekday",      exp.weekday,      got.weekday);
      match("next_day",     exp.next_day,     got.next_day);
      match("next_month",   exp.next_month,   got.next_month);
      match("next_year",    exp.next_year,    got.next_year);
    endfunction
  endclass

  localparam int unsigned RANDOM_ITEMS = 240;
  localparam int unsigned HOLD_CYCLES  = 500;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  gda_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  gda_out_t out_data_o;

  date_scoreboard sb = new();

  // set by the stimulus for a stretch where neither side idles
  bit          steady    = 1'b0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  always #6 clk_i = ~clk_i;

  gregorian_date_adder u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // receiver side: random stalls, plus one long hold-off once a few results
  // are in, so the block ends up full and stalls its input
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i = 1'b1;
      hold_left--;
    end else if (!hold_done && sb.checked == 30) begin
      hold_done   = 1'b1;
      hold_left   = HOLD_CYCLES - 1;
      out_stall_i = 1'b1;
    end else if (steady) begin
      out_stall_i = 1'b0;
    end else begin
      out_stall_i = ($urandom_range(99) < 38);
    end
  end

  // output transfers, sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(out_data_o);
    end
  end

  function automatic gda_in_t mk_date(int unsigned d, int unsigned m, int unsigned y,
                                      int unsigned a);
    gda_in_t r;
    r.start_day   = DAY_W'(d);
    r.start_month = MONTH_W'(m);
    r.start_year  = YEAR_W'(y);
    r.add_count   = ADD_W'(a);
    return r;
  endfunction

  // mostly ordinary dates with short offsets, some of every field's full range;
  // long offsets are kept rare since the block spends a cycle per month
  function automatic gda_in_t rand_date();
    int unsigned d, m, y, a, pick;
    d = ($urandom_range(99) < 15) ? $urandom_range(31) : $urandom_range(28, 1);
    m = ($urandom_range(99) < 10) ? $urandom_range(15) : $urandom_range(12, 1);
    y = ($urandom_range(99) < 15) ? $urandom_range(16383) : $urandom_range(9999, 1);
    pick = $urandom_range(99);
    if (pick < 60) begin
      a = $urandom_range(400);
    end else if (pick < 85) begin
      a = $urandom_range(4095);
    end else begin
      a = $urandom_range(65535);
    end
    return mk_date(d, m, y, a);
  endfunction

  // one input transfer; called and returns at a falling edge
  task automatic push_date(input gda_in_t item);
    if (!steady) begin
      while ($urandom_range(99) < 38) begin
        in_valid_i = 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid_i = 1'b1;
    in_data_i  = item;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    sb.note_input(item);
    @(negedge clk_i);
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: range limits, month ends, leap rule, odd inputs
    push_date(mk_date(1, 1, 1, 0));
    push_date(mk_date(31, 12, 9999, 0));        // last day of a month is kept
    push_date(mk_date(31, 12, 9999, 1));        // into year 10000
    push_date(mk_date(28, 2, 2000, 1));         // leap by the 400 rule
    push_date(mk_date(28, 2, 1900, 1));         // century, not leap
    push_date(mk_date(28, 2, 2024, 1));
    push_date(mk_date(29, 2, 2023, 0));         // day past the month's end
    push_date(mk_date(31, 4, 2021, 0));
    push_date(mk_date(31, 2, 2021, 0));
    push_date(mk_date(30, 11, 2021, 0));
    push_date(mk_date(0, 5, 2020, 0));          // day zero
    push_date(mk_date(0, 12, 2020, 0));
    push_date(mk_date(15, 0, 2020, 10));        // month out of range
    push_date(mk_date(31, 13, 1999, 0));
    push_date(mk_date(7, 14, 1600, 40));
    push_date(mk_date(31, 15, 2100, 29));
    push_date(mk_date(1, 1, 0, 59));            // year zero is leap
    push_date(mk_date(29, 2, 0, 0));
    push_date(mk_date(31, 12, 16383, 0));       // next day wraps the year field
    push_date(mk_date(31, 12, 16383, 1));
    push_date(mk_date(1, 1, 16383, 65535));     // result year beyond the field
    push_date(mk_date(31, 15, 16383, 65535));   // every input bit set
    push_date(mk_date(1, 1, 2000, 65535));
    push_date(mk_date(31, 1, 2023, 0));

    // random part, with one stretch where neither side idles
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      steady = (i >= 100 && i < 160);
      push_date(rand_date());
    end
    steady     = 1'b0;
    in_valid_i = 1'b0;

    while (sb.due_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (60) @(posedge clk_i);

    $display("covered %0d dates, %0d results checked, %0d mismatches",
             sb.noted, sb.checked, sb.mismatches);
    $display("%0d results in leap years, %0d past the year field, %0d with a bad month",
             sb.leap_results, sb.wrapped_years, sb.fixed_months);
    if (sb.mismatches == 0 && sb.due_q.size() == 0) begin
      $display("[gregorian_date_adder] OK");
    end else begin
      $display("[gregorian_date_adder] ERROR");
    end
    $finish;
  end

  // watchdog: several times the slowest correct run
  initial begin
    #48ms;
    $display("[gregorian_date_adder] ERROR");
    $finish;
  end

endmodule
